// ===== hdl/frac_pkg.sv =====
// shared types for the fraction reducer
`timescale 1ns / 1ps
package frac_pkg;

  // classification of an incoming word
  typedef enum logic [1:0] {
    KIND_ZERO_NUM = 2'd0,
    KIND_PASS     = 2'd1,
    KIND_REDUCE   = 2'd2
  } kind_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_GCD  = 3'd1,
    ST_DIVN = 3'd2,
    ST_DIVD = 3'd3,
    ST_OUT  = 3'd4
  } state_t;

endpackage

// ===== hdl/frac_front.sv =====
// front end: classifies each word and computes magnitudes
`timescale 1ns / 1ps
module frac_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [DATA_WIDTH-1:0] in_numerator,
  input  logic [DATA_WIDTH-1:0] in_denominator,
  // towards the queue
  output logic                  fr_valid,
  input  logic                  fr_ready,
  output frac_pkg::kind_t       fr_kind,
  output logic [DATA_WIDTH-1:0] fr_num,
  output logic [DATA_WIDTH-1:0] fr_den,
  output logic [DATA_WIDTH-1:0] fr_an,
  output logic [DATA_WIDTH-1:0] fr_ad
);

  logic                  valid_r;
  frac_pkg::kind_t       kind_r;
  logic [DATA_WIDTH-1:0] num_r, den_r, an_r, ad_r;
  frac_pkg::kind_t       kind_nxt;

  localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

  assign in_full = valid_r && !fr_ready;

  // classify the incoming pair
  always_comb begin
    if (in_numerator == '0) begin
      kind_nxt = frac_pkg::KIND_ZERO_NUM;
    end else if (in_denominator == '0 || in_denominator == ONE) begin
      kind_nxt = frac_pkg::KIND_PASS;
    end else begin
      kind_nxt = frac_pkg::KIND_REDUCE;
    end
  end

  // staging register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_push && !in_full) begin
      valid_r <= 1'b1;
    end else if (fr_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push && !in_full) begin
      kind_r <= kind_nxt;
      num_r  <= in_numerator;
      den_r  <= in_denominator;
      an_r   <= in_numerator[DATA_WIDTH-1] ? (~in_numerator + ONE) : in_numerator;
      ad_r   <= in_denominator[DATA_WIDTH-1] ? (~in_denominator + ONE) : in_denominator;
    end
  end

  assign fr_valid = valid_r;
  assign fr_kind  = kind_r;
  assign fr_num   = num_r;
  assign fr_den   = den_r;
  assign fr_an    = an_r;
  assign fr_ad    = ad_r;

endmodule

// ===== hdl/frac_queue.sv =====
// two-entry queue between front and back ends
`timescale 1ns / 1ps
module frac_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== hdl/frac_back.sv =====
// back end: euclid gcd by restoring division, then two divisions
`timescale 1ns / 1ps
module frac_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  frac_pkg::kind_t       q_kind,
  input  logic [DATA_WIDTH-1:0] q_num,
  input  logic [DATA_WIDTH-1:0] q_den,
  input  logic [DATA_WIDTH-1:0] q_an,
  input  logic [DATA_WIDTH-1:0] q_ad,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [DATA_WIDTH-1:0] out_reduced_numerator,
  output logic [DATA_WIDTH-1:0] out_reduced_denominator,
  output logic                  out_was_reduced
);

  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

  frac_pkg::state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0] an_r, ad_r;
  // divider: remainder, quotient/dividend shift, divisor
  logic [DATA_WIDTH-1:0] rem_r, quo_r, dvs_r, qn_r, ga_r, gb_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic [DATA_WIDTH-1:0] rn_r, rd_r;
  logic                  red_r, full_r;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   shifted;
  logic                  fits;
  logic                  last;

  // one restoring division step
  always_comb begin
    shifted = {rem_r, quo_r[DATA_WIDTH-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = !trial[DATA_WIDTH];
    last    = cnt_r == CW'(1);
  end

  assign q_ready   = (state_r == frac_pkg::ST_IDLE) && !full_r;
  assign out_empty = !full_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frac_pkg::ST_IDLE: begin
        if (q_valid && !full_r) begin
          if (q_kind == frac_pkg::KIND_REDUCE) state_nxt = frac_pkg::ST_GCD;
          else state_nxt = frac_pkg::ST_OUT;
        end
      end
      frac_pkg::ST_GCD: begin
        if (last) begin
          if ((fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0]) == '0)
            state_nxt = frac_pkg::ST_DIVN;
        end
      end
      frac_pkg::ST_DIVN: if (last) state_nxt = frac_pkg::ST_DIVD;
      frac_pkg::ST_DIVD: if (last) state_nxt = frac_pkg::ST_OUT;
      frac_pkg::ST_OUT:  state_nxt = frac_pkg::ST_IDLE;
      default:           state_nxt = frac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= frac_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (state_r == frac_pkg::ST_OUT) begin
      full_r <= 1'b1;
    end else if (out_pop && full_r) begin
      full_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      frac_pkg::ST_IDLE: begin
        // load only when a word is taken, so a waiting result stays put
        if (q_valid && !full_r) begin
          an_r  <= q_an;
          ad_r  <= q_ad;
          neg_r <= q_num[DATA_WIDTH-1] ^ q_den[DATA_WIDTH-1];
          rem_r <= '0;
          quo_r <= q_an;
          dvs_r <= q_ad;
          ga_r  <= q_an;
          gb_r  <= q_ad;
          cnt_r <= CW'(DATA_WIDTH);
          if (q_kind == frac_pkg::KIND_ZERO_NUM) begin
            rn_r  <= '0;
            rd_r  <= ONE;
          end else begin
            rn_r  <= q_num;
            rd_r  <= q_den;
          end
          red_r <= 1'b0;
        end
      end
      frac_pkg::ST_GCD: begin
        cnt_r <= cnt_r - CW'(1);
        rem_r <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], fits};
        if (last) begin
          cnt_r <= CW'(DATA_WIDTH);
          rem_r <= '0;
          if ((fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0]) == '0) begin
            // gcd is dvs_r: divide numerator magnitude next
            gb_r  <= dvs_r;
            quo_r <= an_r;
          end else begin
            quo_r <= dvs_r;
            dvs_r <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
          end
        end
      end
      frac_pkg::ST_DIVN: begin
        cnt_r <= cnt_r - CW'(1);
        rem_r <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], fits};
        if (last) begin
          cnt_r <= CW'(DATA_WIDTH);
          rem_r <= '0;
          qn_r  <= {quo_r[DATA_WIDTH-2:0], fits};
          quo_r <= ad_r;
        end
      end
      frac_pkg::ST_DIVD: begin
        cnt_r <= cnt_r - CW'(1);
        rem_r <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_r <= {quo_r[DATA_WIDTH-2:0], fits};
        if (last) begin
          // coprime with differing magnitudes keeps the pair as it came
          if (!(gb_r == ONE && an_r != ad_r)) begin
            rn_r  <= neg_r ? (~qn_r + ONE) : qn_r;
            rd_r  <= {quo_r[DATA_WIDTH-2:0], fits};
            red_r <= gb_r != ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_reduced_numerator   = rn_r;
  assign out_reduced_denominator = rd_r;
  assign out_was_reduced         = red_r;

endmodule

// ===== hdl/fraction_reducer.sv =====
// fraction reducer top level: front end, queue, gcd/divide back end
// one divider in the back end serves the gcd and both divisions
// each remainder and each quotient is one DATA_WIDTH-step restoring division
// the back end takes a new word only when idle and its last result is popped
// a zero numerator or pass-through pair skips the divider
// reset: synchronous active-low rst_n empties the staging, queue and result
`timescale 1ns / 1ps
module fraction_reducer #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [DATA_WIDTH-1:0] in_numerator,
  input  logic [DATA_WIDTH-1:0] in_denominator,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [DATA_WIDTH-1:0] out_reduced_numerator,
  output logic [DATA_WIDTH-1:0] out_reduced_denominator,
  output logic                  out_was_reduced
);

  localparam int QW = 2 + 4 * DATA_WIDTH;

  logic                  fr_valid, fr_ready, q_valid, q_ready;
  frac_pkg::kind_t       fr_kind, q_kind;
  logic [DATA_WIDTH-1:0] fr_num, fr_den, fr_an, fr_ad;
  logic [DATA_WIDTH-1:0] q_num, q_den, q_an, q_ad;
  logic [QW-1:0]         q_data;

  frac_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_numerator, .in_denominator,
    .fr_valid, .fr_ready, .fr_kind, .fr_num, .fr_den, .fr_an, .fr_ad
  );

  // queue between classification and arithmetic
  frac_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n,
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  ({fr_kind, fr_num, fr_den, fr_an, fr_ad}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_kind = frac_pkg::kind_t'(q_data[QW-1 -: 2]);
  assign q_num  = q_data[4*DATA_WIDTH-1 -: DATA_WIDTH];
  assign q_den  = q_data[3*DATA_WIDTH-1 -: DATA_WIDTH];
  assign q_an   = q_data[2*DATA_WIDTH-1 -: DATA_WIDTH];
  assign q_ad   = q_data[DATA_WIDTH-1:0];

  frac_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_kind, .q_num, .q_den, .q_an, .q_ad,
    .out_empty, .out_pop, .out_reduced_numerator, .out_reduced_denominator,
    .out_was_reduced
  );

endmodule

// ===== sim/fraction_reducer_tb.sv =====
// self-checking testbench for the fraction reducer: queue driver, monitor and predictor
`timescale 1ns / 1ps
module fraction_reducer_tb;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
  } frac_word_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         reduced;
  } reduced_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [W-1:0] in_numerator = '0;
  logic [W-1:0] in_denominator = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [W-1:0] out_reduced_numerator;
  logic [W-1:0] out_reduced_denominator;
  logic out_was_reduced;

  frac_word_t pending_words[$];
  reduced_word_t expected_fracs[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int reduced_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_cycles = 0;
  bit stimulus_done = 1'b0;

  fraction_reducer #(.DATA_WIDTH(W)) dut (.*);

  // clock
  always #4 clk = ~clk;

  // euclid on magnitudes
  function automatic logic [W:0] gcd_mag(logic [W:0] a, logic [W:0] b);
    logic [W:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // reduced fraction for one word
  function automatic reduced_word_t reduce_frac(frac_word_t w);
    reduced_word_t r;
    logic [W:0] an, ad, g, qn, qd;
    logic [W:0] neg_qn;
    r = '{num: w.num, den: w.den, reduced: 1'b0};
    if (w.num == 0) begin
      r.den = 1;
      return r;
    end
    if (w.den == 0 || w.den == 1) return r;
    an = w.num[W-1] ? ({1'b0, ~w.num} + 1) : {1'b0, w.num};
    ad = w.den[W-1] ? ({1'b0, ~w.den} + 1) : {1'b0, w.den};
    g = gcd_mag(an, ad);
    if (g == 1 && an != ad) return r;
    qn = an / g;
    qd = ad / g;
    neg_qn = ~qn + 1;
    r.num = (w.num[W-1] != w.den[W-1]) ? neg_qn[W-1:0] : qn[W-1:0];
    r.den = qd[W-1:0];
    r.reduced = (g > 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    mismatches++;
    $display("mismatch on %s: got %h want %h (word %0d)", what, got, want,
             words_checked);
  endtask

  // accepted input words, taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      expected_fracs.push_back(reduce_frac('{num: in_numerator, den: in_denominator}));
      words_sent++;
      void'(pending_words.pop_front());
    end
  end

  // driver: offers words from the pending queue at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_numerator <= pending_words[0].num;
        in_denominator <= pending_words[0].den;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver: pop requests at the falling edge, long hold counted here
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // monitor: checks each popped word at the rising edge
  always @(posedge clk) begin
    reduced_word_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_fracs.size() == 0) begin
        mismatches++;
        $display("unexpected result word %h/%h", out_reduced_numerator,
                 out_reduced_denominator);
      end else begin
        want = expected_fracs.pop_front();
        if (out_reduced_numerator !== want.num)
          report_mismatch("numerator", out_reduced_numerator, want.num);
        if (out_reduced_denominator !== want.den)
          report_mismatch("denominator", out_reduced_denominator, want.den);
        if (out_was_reduced !== want.reduced)
          report_mismatch("was_reduced", out_was_reduced, want.reduced);
        if (want.reduced) reduced_seen++;
        words_checked++;
      end
    end
  end

  // random value of random sign, mostly small so that reductions happen often
  function automatic logic [W-1:0] rand_val(int mode);
    logic [W-1:0] v;
    case (mode)
      0: v = $urandom_range(12);
      1: v = $urandom_range(4096);
      default: v = $urandom;
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic add_word(input logic [W-1:0] n, input logic [W-1:0] d);
    pending_words.push_back('{num: n, den: d});
  endtask

  task automatic add_random(input int count);
    logic [W-1:0] f, n, d;
    repeat (count) begin
      if ($urandom_range(3) != 0) begin
        // common factor times two small cofactors
        f = $urandom_range(1, 1 << $urandom_range(1, 20));
        n = f * $urandom_range(0, 300);
        d = f * $urandom_range(0, 300);
        if ($urandom_range(1)) n = -n;
        if ($urandom_range(1)) d = -d;
      end else begin
        n = rand_val($urandom_range(2));
        d = rand_val($urandom_range(2));
      end
      add_word(n, d);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_fracs.size() > 0 || in_push)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // stimulus phases
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    add_word(0, 5);
    add_word(0, 0);
    add_word(7, 0);
    add_word(-7, 1);
    add_word(3, -1);
    add_word(-1, -1);
    add_word(5, 5);
    add_word(-6, 6);
    add_word(6, -4);
    add_word(-6, -4);
    add_word(7, 3);
    add_word(-7, -3);
    add_word(32'h8000_0000, 32'h8000_0000);
    add_word(32'h8000_0000, 2);
    add_word(4, 32'h8000_0000);
    add_word(32'h8000_0000, 3);
    add_word(32'h7fff_ffff, 32'h7fff_ffff);
    add_word(32'h7fff_ffff, 32'h8000_0001);
    add_word(32'hffff_ffff, 32'h8000_0000);
    add_word(32'h4000_0000, 32'hc000_0000);
    add_word(32'h5555_5555, 32'haaaa_aaaa);
    add_word(32'hffff_fffe, 32'h7fff_fffe);
    drain();

    add_random(400);
    drain();
    send_idle_pct = 88;
    add_random(300);
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 88;
    add_random(300);
    drain();
    send_idle_pct = 35;
    pop_stall_pct = 35;
    add_random(300);
    drain();

    // long hold on the result side so the block fills and pushes back
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_cycles = 4000;
    add_random(300);
    drain();
    stimulus_done = 1'b1;
  end

  // end of run
  always @(posedge clk) begin
    if (stimulus_done) begin
      $display("%0d words sent, %0d checked, %0d reduced, %0d mismatches",
               words_sent, words_checked, reduced_seen, mismatches);
      $display("covered sign corners, zero and unit cases, idle and stall phases");
      if (mismatches == 0 && expected_fracs.size() == 0)
        $display("SUCCESS");
      else
        $display("FAILURE");
      $finish;
    end else if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
